// ===== rtl/ccc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the month length table for the clock calendar counter.
// No dependencies; imported by the top level, the port checker and the testbench.

package ccc_pkg;

    // Beat kinds carried on the input tuser field.
    typedef logic [1:0] op_t;
    localparam op_t OP_TICK      = 2'd0;
    localparam op_t OP_LOAD_TIME = 2'd1;
    localparam op_t OP_LOAD_DATE = 2'd2;

    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Counter limits.
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [6:0] MIN_MAX   = 7'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd11;
    localparam logic [4:0] MONTH_MAX = 5'd12;

    // Reset values.
    localparam logic [3:0]  MONTH_RST = 4'd1;
    localparam logic [4:0]  DAY_RST   = 5'd1;
    localparam logic [15:0] YEAR_RST  = 16'd2000;

    // Input beat, hour in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] load_year;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic        load_pm;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [3:0]  load_hour;
    } in_beat_t;

    // Result beat, hour in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] cur_year;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic        cur_pm;
        logic [5:0]  cur_second;
        logic [5:0]  cur_minute;
        logic [3:0]  cur_hour;
    } out_beat_t;

    // Days in a month without leap years; codes outside 1..12 count as 31.
    function automatic logic [4:0] month_length(input logic [3:0] month);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/clock_calendar_counter_top.sv =====
`timescale 1ns / 1ps
// 12-hour clock with AM/PM flag cascaded into a month/day/year calendar.
// Depends on ccc_pkg for beat layouts, op codes and the month length table.
//
// Usage:
//   The slave stream carries one command per beat: tuser selects a one-second
//   tick, a load of the time or a load of the date, and tdata holds the load
//   values. Every accepted beat produces exactly one master beat holding the
//   time and date after that command.
//   An accepted beat passes through the input register, then through the
//   counter update into the result register. Throughput is one beat per
//   cycle while the receiver is ready, since the cascaded counters update
//   combinationally on the way into the result register.
//   When the receiver stalls, the result register holds its beat, the input
//   register fills, and s_axis_tready falls; it rises again in the cycle in
//   which m_axis_tready returns, so no beat is lost or repeated.
//   An asynchronous reset (rst_n low) empties both registers and sets the
//   clock to 0:00:00 AM on January 1st, 2000.
//   Loaded values are stored unchecked; tuser code 3 changes nothing and
//   still returns the current time and date.

module clock_calendar_counter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: load_hour[3:0], load_minute[9:4], load_second[15:10],
    // load_pm[16], load_month[20:17], load_day[25:21], load_year[41:26], zeros
    input  logic [ccc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0]
    input  logic [ccc_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: cur_hour[3:0], cur_minute[9:4], cur_second[15:10],
    // cur_pm[16], cur_month[20:17], cur_day[25:21], cur_year[41:26], zeros
    output logic [ccc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import ccc_pkg::*;

    // Pipeline registers
    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    op_t       in_op_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      advance;

    // Clock and calendar state
    logic [5:0]  sec_reg,  sec_next;
    logic [5:0]  min_reg,  min_next;
    logic [3:0]  hour_reg, hour_next;
    logic        pm_reg,   pm_next;
    logic [3:0]  mon_reg,  mon_next;
    logic [4:0]  day_reg,  day_next;
    logic [15:0] year_reg, year_next;

    // Tick arithmetic
    logic [5:0]  tick_sec;
    logic [6:0]  tick_min;
    logic [4:0]  tick_hour;
    logic        tick_pm;
    logic        day_adv;
    logic [5:0]  adv_day;
    logic [4:0]  adv_mon;
    logic [15:0] adv_year;

    // Handshake: the result register moves when empty or taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Seconds, minutes and hours cascade, then the day advance on PM to AM.
    always_comb
    begin
        if (sec_reg >= SEC_MAX)
        begin
            tick_sec = 6'd0;
            tick_min = {1'b0, min_reg} + 7'd1;
        end
        else
        begin
            tick_sec = sec_reg + 6'd1;
            tick_min = {1'b0, min_reg};
        end

        if (tick_min > MIN_MAX)
        begin
            tick_min  = 7'd0;
            tick_hour = {1'b0, hour_reg} + 5'd1;
        end
        else
        begin
            tick_hour = {1'b0, hour_reg};
        end

        if (tick_hour > HOUR_MAX)
        begin
            tick_hour = 5'd0;
            tick_pm   = ~pm_reg;
        end
        else
        begin
            tick_pm = pm_reg;
        end

        day_adv = pm_reg && !tick_pm;

        // Next day: wrap to the first at month end, month past 12 rolls the year.
        adv_day  = {1'b0, day_reg} + 6'd1;
        adv_mon  = {1'b0, mon_reg};
        adv_year = year_reg;
        if (adv_day > {1'b0, month_length(mon_reg)})
        begin
            adv_day = 6'd1;
            adv_mon = adv_mon + 5'd1;
        end
        if (adv_mon > MONTH_MAX)
        begin
            adv_mon  = 5'd1;
            adv_year = year_reg + 16'd1;
        end
    end

    // Select the next state by command.
    always_comb
    begin
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        pm_next   = pm_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        year_next = year_reg;
        case (in_op_reg)
            OP_TICK:
            begin
                sec_next  = tick_sec;
                min_next  = tick_min[5:0];
                hour_next = tick_hour[3:0];
                pm_next   = tick_pm;
                if (day_adv)
                begin
                    mon_next  = adv_mon[3:0];
                    day_next  = adv_day[4:0];
                    year_next = adv_year;
                end
            end
            OP_LOAD_TIME:
            begin
                hour_next = in_data_reg.load_hour;
                min_next  = in_data_reg.load_minute;
                sec_next  = in_data_reg.load_second;
                pm_next   = in_data_reg.load_pm;
            end
            OP_LOAD_DATE:
            begin
                mon_next  = in_data_reg.load_month;
                day_next  = in_data_reg.load_day;
                year_next = in_data_reg.load_year;
            end
            default:
            begin
                sec_next = sec_reg;
            end
        endcase
    end

    // Input register: takes a beat whenever it is empty or drains this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= in_beat_t'(s_axis_tdata);
            in_op_reg   <= s_axis_tuser;
        end
    end

    // Counter state commits when a command moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 4'd0;
            pm_reg        <= 1'b0;
            mon_reg       <= MONTH_RST;
            day_reg       <= DAY_RST;
            year_reg      <= YEAR_RST;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                sec_reg  <= sec_next;
                min_reg  <= min_next;
                hour_reg <= hour_next;
                pm_reg   <= pm_next;
                mon_reg  <= mon_next;
                day_reg  <= day_next;
                year_reg <= year_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg.pad        <= '0;
            out_data_reg.cur_hour   <= hour_next;
            out_data_reg.cur_minute <= min_next;
            out_data_reg.cur_second <= sec_next;
            out_data_reg.cur_pm     <= pm_next;
            out_data_reg.cur_month  <= mon_next;
            out_data_reg.cur_day    <= day_next;
            out_data_reg.cur_year   <= year_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

// ===== rtl/ccc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the clock calendar counter, bound to the top level.
// Depends on ccc_pkg for op codes and port widths.

module ccc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ccc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [ccc_pkg::OP_W-1:0]         s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ccc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import ccc_pkg::*;

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // With the receiver ready, every accepted beat shows up once it has passed the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && m_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result beat missing two cycles after input beat");

    // A time load returns the loaded time unchanged.
    a_load_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && s_axis_tuser == OP_LOAD_TIME && m_axis_tready) ##1 m_axis_tready
        |=> m_axis_tdata[16:0] == $past(s_axis_tdata[16:0], 2))
        else $error("loaded time not returned");

    // A date load returns the loaded date unchanged.
    a_load_date: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && s_axis_tuser == OP_LOAD_DATE && m_axis_tready) ##1 m_axis_tready
        |=> m_axis_tdata[41:17] == $past(s_axis_tdata[41:17], 2))
        else $error("loaded date not returned");

endmodule

bind clock_calendar_counter_top ccc_checker u_ccc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_clock_calendar_counter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for clock_calendar_counter_top: ticks, time loads and date loads
// on the slave stream, each result beat compared with a built-in clock and calendar model.
// Depends on ccc_pkg and the top level under rtl.

module tb_clock_calendar_counter_top;

    import ccc_pkg::*;

    // The fourth command code leaves the clock untouched.
    localparam op_t OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 20;

    // One queued command; a pause entry sends nothing and waits for all results.
    typedef struct {
        op_t      op;
        in_beat_t load;
        bit       pause;
    } command_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0] s_axis_tuser = OP_TICK;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    command_t  command_queue[$];
    out_beat_t expected_readings[$];
    out_beat_t clock_state;
    int        mismatch_count = 0;
    int        queued_items = 0;
    bit        beat_taken = 1'b0;
    bit        pausing = 1'b0;
    int        send_gap = 0;
    int        send_quiet = 0;
    int        stall_left = 0;
    int        ready_quiet = 0;

    clock_calendar_counter_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Days in a month with no leap years; codes outside 1..12 count as 31.
    function automatic int days_in(input int month);
        case (month)
            2:           return 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Next clock and calendar state after one command.
    function automatic out_beat_t apply_command(input out_beat_t st, input op_t op,
                                                input in_beat_t ld);
        int   sec;
        int   mins;
        int   hrs;
        int   dd;
        int   mm;
        logic was_pm;
        case (op)
            OP_TICK:
            begin
                was_pm = st.cur_pm;
                sec    = int'(st.cur_second);
                mins   = int'(st.cur_minute);
                hrs    = int'(st.cur_hour);
                if (sec >= int'(SEC_MAX))
                begin
                    sec  = 0;
                    mins = mins + 1;
                end
                else
                begin
                    sec = sec + 1;
                end
                // Minute and hour wraps also catch loaded values that were out of range.
                if (mins > int'(MIN_MAX))
                begin
                    mins = 0;
                    hrs  = hrs + 1;
                end
                if (hrs > int'(HOUR_MAX))
                begin
                    hrs       = 0;
                    st.cur_pm = ~st.cur_pm;
                end
                st.cur_second = sec[5:0];
                st.cur_minute = mins[5:0];
                st.cur_hour   = hrs[3:0];
                // Midnight: the flag fell from PM to AM, so the calendar moves one day.
                if (was_pm && !st.cur_pm)
                begin
                    dd = int'(st.cur_day) + 1;
                    mm = int'(st.cur_month);
                    if (dd > days_in(mm))
                    begin
                        dd = 1;
                        mm = mm + 1;
                    end
                    if (mm > int'(MONTH_MAX))
                    begin
                        mm = 1;
                        st.cur_year = st.cur_year + 16'd1;
                    end
                    st.cur_day   = dd[4:0];
                    st.cur_month = mm[3:0];
                end
            end
            OP_LOAD_TIME:
            begin
                st.cur_hour   = ld.load_hour;
                st.cur_minute = ld.load_minute;
                st.cur_second = ld.load_second;
                st.cur_pm     = ld.load_pm;
            end
            OP_LOAD_DATE:
            begin
                st.cur_month = ld.load_month;
                st.cur_day   = ld.load_day;
                st.cur_year  = ld.load_year;
            end
            default:
            begin
            end
        endcase
        return st;
    endfunction

    // Every load field random over its full width; padding stays zero.
    function automatic in_beat_t random_load();
        in_beat_t ld;
        ld             = '0;
        ld.load_hour   = 4'($urandom);
        ld.load_minute = 6'($urandom);
        ld.load_second = 6'($urandom);
        ld.load_pm     = 1'($urandom);
        ld.load_month  = 4'($urandom);
        ld.load_day    = 5'($urandom);
        ld.load_year   = 16'($urandom);
        return ld;
    endfunction

    function automatic in_beat_t make_time(input logic [3:0] hrs, input logic [5:0] mins,
                                           input logic [5:0] sec, input logic pm);
        in_beat_t ld;
        ld             = random_load();
        ld.load_hour   = hrs;
        ld.load_minute = mins;
        ld.load_second = sec;
        ld.load_pm     = pm;
        return ld;
    endfunction

    function automatic in_beat_t make_date(input logic [3:0] mm, input logic [4:0] dd,
                                           input logic [15:0] yy);
        in_beat_t ld;
        ld            = random_load();
        ld.load_month = mm;
        ld.load_day   = dd;
        ld.load_year  = yy;
        return ld;
    endfunction

    task automatic queue_command(input op_t op, input in_beat_t ld);
        command_t cmd;
        cmd.op    = op;
        cmd.load  = ld;
        cmd.pause = 1'b0;
        command_queue.push_back(cmd);
        if (op != OP_UNUSED)
            queued_items++;
    endtask

    task automatic queue_pause();
        command_t cmd;
        cmd.op    = OP_UNUSED;
        cmd.load  = '0;
        cmd.pause = 1'b1;
        command_queue.push_back(cmd);
    endtask

    // Idle length: mostly none, some short, a few long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on every accepted command beat and check every accepted result beat.
    always @(posedge clk)
    begin : observe_streams
        out_beat_t got;
        out_beat_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                clock_state = apply_command(clock_state, s_axis_tuser, s_axis_tdata);
                expected_readings.push_back(clock_state);
                beat_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %h", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compare_field("cur_hour", 32'(want.cur_hour), 32'(got.cur_hour));
                    compare_field("cur_minute", 32'(want.cur_minute), 32'(got.cur_minute));
                    compare_field("cur_second", 32'(want.cur_second), 32'(got.cur_second));
                    compare_field("cur_pm", 32'(want.cur_pm), 32'(got.cur_pm));
                    compare_field("cur_month", 32'(want.cur_month), 32'(got.cur_month));
                    compare_field("cur_day", 32'(want.cur_day), 32'(got.cur_day));
                    compare_field("cur_year", 32'(want.cur_year), 32'(got.cur_year));
                    compare_field("pad", 32'(want.pad), 32'(got.pad));
                end
            end
        end
    end

    // Command driver: one beat at a time from the queue, with random gaps and pauses.
    always @(negedge clk)
    begin : drive_commands
        logic     next_valid;
        command_t cmd;
        if (rst_n)
        begin
            next_valid = s_axis_tvalid && !beat_taken;
            beat_taken = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pausing)
                begin
                    if (expected_readings.size() == 0)
                        pausing = 1'b0;
                end
                else if (command_queue.size() > 0)
                begin
                    cmd = command_queue.pop_front();
                    if (cmd.pause)
                    begin
                        pausing = 1'b1;
                    end
                    else
                    begin
                        s_axis_tdata <= cmd.load;
                        s_axis_tuser <= cmd.op;
                        next_valid = 1'b1;
                        if (send_quiet > 0)
                        begin
                            send_quiet--;
                            send_gap = 0;
                        end
                        else
                        begin
                            send_gap = draw_gap();
                            if ($urandom_range(0, 49) == 0)
                                send_quiet = $urandom_range(20, 80);
                        end
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Result receiver: random stalls with stretches of steady readiness.
    always @(negedge clk)
    begin : accept_results
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (ready_quiet > 0)
                    ready_quiet--;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
                else if ($urandom_range(0, 99) == 0)
                    ready_quiet = $urandom_range(30, 120);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : run_test
        int          target;
        int          r;
        int          len;
        int          ticks;
        logic [3:0]  mm;
        logic [4:0]  dd;
        logic [15:0] yy;
        bit          mid_pause_done;

        clock_state            = '0;
        clock_state.cur_month  = MONTH_RST;
        clock_state.cur_day    = DAY_RST;
        clock_state.cur_year   = YEAR_RST;
        mid_pause_done         = 1'b0;

        // Directed: unused code, carries through the whole cascade, out-of-range loads.
        queue_command(OP_UNUSED, random_load());
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59, 6'd59, 1'b1));
        queue_command(OP_LOAD_DATE, make_date(4'd12, 5'd31, 16'hFFFF));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59, 6'd59, 1'b0));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_TIME, make_time(4'd15, 6'd63, 6'd63, 1'b1));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_DATE, make_date(4'd0, 5'd31, 16'd0));
        queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59, 6'd59, 1'b1));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_DATE, make_date(4'd2, 5'd28, 16'd1999));
        queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59, 6'd59, 1'b1));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_DATE, make_date(4'd15, 5'd0, 16'hFFFF));
        queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59, 6'd59, 1'b1));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_DATE, make_date(4'd4, 5'd30, 16'd2023));
        queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59, 6'd59, 1'b1));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_TIME, make_time(4'd3, 6'd62, 6'd10, 1'b0));
        queue_command(OP_TICK, random_load());
        queue_command(OP_LOAD_TIME, make_time(4'd13, 6'd0, 6'd0, 1'b1));
        queue_command(OP_TICK, random_load());
        queue_pause();

        // Random: mostly date and time loads near a day boundary followed by ticks.
        target = queued_items + RANDOM_ITEMS;
        while (queued_items < target)
        begin
            if (!mid_pause_done && queued_items >= target - RANDOM_ITEMS / 2)
            begin
                queue_pause();
                mid_pause_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    mm  = 4'($urandom_range(1, 12));
                    len = days_in(int'(mm));
                    case ($urandom_range(0, 3))
                        0, 1:    dd = 5'(len);
                        2:       dd = 5'(len - 1);
                        default: dd = 5'($urandom_range(1, len));
                    endcase
                    yy = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
                    queue_command(OP_LOAD_DATE, make_date(mm, dd, yy));
                end
                if ($urandom_range(0, 9) < 6)
                    queue_command(OP_LOAD_TIME, make_time(4'd11, 6'd59,
                                  6'($urandom_range(45, 59)), $urandom_range(0, 3) != 0));
                else
                    queue_command(OP_LOAD_TIME, make_time(4'($urandom_range(0, 11)),
                                  6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                                  1'($urandom_range(0, 1))));
                ticks = $urandom_range(1, 20);
                repeat (ticks) queue_command(OP_TICK, random_load());
            end
            else
            begin
                // Noise: any code with loads over the full field widths.
                queue_command(op_t'($urandom_range(0, 3)), random_load());
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() > 0 || pausing || s_axis_tvalid)
            @(posedge clk);
        while (expected_readings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_clock_calendar_counter_top: PASS");
        else
            $display("tb_clock_calendar_counter_top: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #10ms;
        $display("tb_clock_calendar_counter_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ccc_pkg.sv
rtl/clock_calendar_counter_top.sv
rtl/ccc_checker.sv
sim/tb_clock_calendar_counter_top.sv
